FILE: hw/rtl/ssra_pkg.sv
// Shared constants, codes and request types of the swap slot allocator.
package ssra_pkg;

  localparam int NUM_SLOTS  = 1024;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int REF_W      = COUNT_BITS + 1;
  localparam int CFG_W      = 11;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  // The used bitmap is stored as words of WORD_BITS slots each.
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int NUM_WORDS  = NUM_SLOTS / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(1024);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_SHARE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREE_REL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SAT      = 2'd3;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } bm_rd_t;

  typedef struct packed {
    logic                 en;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } bm_wr_t;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [SLOT_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } rc_req_t;

endpackage

FILE: hw/rtl/ssra_if.sv
// Valid/ready channel interfaces for requests and results.
interface ssra_in_if import ssra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output opcode, output slot, input ready);
  modport sink (input valid, input opcode, input slot, output ready);
endinterface

interface ssra_out_if import ssra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic [REF_W-1:0]  references;
  logic [STAT_W-1:0] status;

  modport source (output valid, output slot_index, output references, output status,
                  input ready);
  modport sink (input valid, input slot_index, input references, input status,
                output ready);
endinterface

FILE: hw/rtl/ssra_bitmap.sv
// Used-slot bitmap memory with per-word valid bits and a full-word summary.
module ssra_bitmap import ssra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bm_rd_t               rd_i,
  input  bm_wr_t               wr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  output logic [WADDR_W-1:0]   free_word_o,
  output logic                 any_free_o
);

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic [NUM_WORDS-1:0] vld_q;
  logic [NUM_WORDS-1:0] full_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  // A word never written since reset reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      vld_q    <= '0;
      full_q   <= '0;
    end else begin
      if (rd_i.en) begin
        rd_vld_q <= vld_q[rd_i.addr];
      end
      if (wr_i.en) begin
        vld_q[wr_i.addr]  <= 1'b1;
        full_q[wr_i.addr] <= &wr_i.data;
      end
    end
  end

  assign rd_data_o  = rd_vld_q ? rd_data_q : '0;
  assign any_free_o = ~&full_q;

  always_comb begin
    free_word_o = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) free_word_o = WADDR_W'(i);
    end
  end

endmodule

FILE: hw/rtl/ssra_refcnt.sv
// Extra-reference count memory, one port, registered read data.
module ssra_refcnt import ssra_pkg::*; (
  input  logic                  clk_i,
  input  rc_req_t               req_i,
  output logic [COUNT_BITS-1:0] rd_data_o
);

  logic [COUNT_BITS-1:0] mem_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0] rd_data_q;

  // Counts only matter for used slots, and a slot is always written with
  // zero when it becomes used, so the store needs no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/swap_slot_refcount_allocator_unit.sv
// Top level: swap slot allocator with reference counts, sequencer and result register.
//
//   Channel  Dir  Handshake          Carries
//   in_i     in   valid/ready        opcode, slot
//   out_o    out  valid/ready        slot_index, references, status
//   cfg      in   cfg_we_i only      cfg_wdata_i = search bound
//
// An item goes through accept and memory read, read-modify-write of the
// bitmap word and count, then hand-off to the result register. An allocate that
// finds every bitmap word full, or a search bound of zero, skips the read step.
// The registered read data of the memories sets this split. Reset is asynchronous;
// no clearing pass is needed, since per-word valid bits make the bitmap read as
// free after reset. A new item is accepted while a result still waits; a stalled
// output holds the item after.
module swap_slot_refcount_allocator_unit import ssra_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ssra_in_if.sink          in_i,
  ssra_out_if.source       out_o
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [REF_W-1:0]  references;
    logic [STAT_W-1:0] status;
  } res_t;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [REF_W-1:0] SAT_REFS = REF_W'(1) << COUNT_BITS;

  logic [1:0]            state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [WADDR_W-1:0]    aw_q, aw_d;
  logic [CFG_W-1:0]      cfg_q;
  res_t                  res_q, res_d;
  res_t                  out_res_q;
  logic                  out_vld_q, out_vld_d;
  logic                  load;

  bm_rd_t                bm_rd;
  bm_wr_t                bm_wr;
  rc_req_t               rc_req;
  logic [WORD_BITS-1:0]  bm_rdata;
  logic [WADDR_W-1:0]    bm_free_word;
  logic                  bm_any_free;
  logic [COUNT_BITS-1:0] cnt;

  logic [CFG_W-1:0]      bound;
  logic [BIT_W-1:0]      zb;
  logic [SLOT_W-1:0]     cand;
  logic                  used;
  logic [WORD_BITS-1:0]  sel_mask;

  ssra_bitmap u_bitmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (bm_rd),
    .wr_i        (bm_wr),
    .rd_data_o   (bm_rdata),
    .free_word_o (bm_free_word),
    .any_free_o  (bm_any_free)
  );

  ssra_refcnt u_refcnt (
    .clk_i     (clk_i),
    .req_i     (rc_req),
    .rd_data_o (cnt)
  );

  assign bound = (cfg_q > CFG_W'(NUM_SLOTS)) ? CFG_W'(NUM_SLOTS) : cfg_q;
  assign used  = bm_rdata[slot_q[BIT_W-1:0]];
  assign cand  = {aw_q, zb};

  always_comb begin
    zb = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!bm_rdata[i]) zb = BIT_W'(i);
    end
  end

  assign sel_mask = (op_q == OP_ALLOC) ? (WORD_BITS'(1) << zb)
                                       : (WORD_BITS'(1) << slot_q[BIT_W-1:0]);

  assign in_i.ready = (state_q == S_IDLE);
  assign load       = (state_q == S_DONE) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    slot_d  = slot_q;
    aw_d    = aw_q;
    res_d   = res_q;
    bm_rd   = '0;
    bm_wr   = '0;
    rc_req  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.opcode;
          slot_d  = in_i.slot;
          state_d = S_READ;
          if (in_i.opcode == OP_ALLOC) begin
            if (!bm_any_free || bound == '0) begin
              res_d   = '{slot_index: '0, references: '0, status: STAT_FULL};
              state_d = S_DONE;
            end else begin
              bm_rd.en   = 1'b1;
              bm_rd.addr = bm_free_word;
              aw_d       = bm_free_word;
            end
          end else begin
            bm_rd.en     = 1'b1;
            bm_rd.addr   = in_i.slot[SLOT_W-1:BIT_W];
            rc_req.rd_en = 1'b1;
            rc_req.addr  = in_i.slot;
          end
        end
      end
      S_READ: begin
        state_d    = S_DONE;
        bm_wr.addr = (op_q == OP_ALLOC) ? aw_q : slot_q[SLOT_W-1:BIT_W];
        case (op_q)
          OP_ALLOC: begin
            // The lowest free slot overall; if it lies past the bound, none below does.
            if ({1'b0, cand} < bound) begin
              bm_wr.en     = 1'b1;
              bm_wr.data   = bm_rdata | sel_mask;
              rc_req.wr_en = 1'b1;
              rc_req.addr  = cand;
              rc_req.data  = '0;
              res_d = '{slot_index: cand, references: REF_W'(1), status: STAT_OK};
            end else begin
              res_d = '{slot_index: '0, references: '0, status: STAT_FULL};
            end
          end
          OP_SHARE: begin
            rc_req.addr = slot_q;
            if (!used) begin
              bm_wr.en     = 1'b1;
              bm_wr.data   = bm_rdata | sel_mask;
              rc_req.wr_en = 1'b1;
              rc_req.data  = '0;
              res_d = '{slot_index: slot_q, references: REF_W'(1), status: STAT_OK};
            end else if (&cnt) begin
              res_d = '{slot_index: slot_q, references: SAT_REFS, status: STAT_SAT};
            end else begin
              rc_req.wr_en = 1'b1;
              rc_req.data  = cnt + COUNT_BITS'(1);
              res_d = '{slot_index: slot_q, references: REF_W'(cnt) + REF_W'(2),
                        status: STAT_OK};
            end
          end
          OP_RELEASE: begin
            rc_req.addr = slot_q;
            if (!used) begin
              res_d = '{slot_index: slot_q, references: '0, status: STAT_FREE_REL};
            end else if (cnt != '0) begin
              rc_req.wr_en = 1'b1;
              rc_req.data  = cnt - COUNT_BITS'(1);
              res_d = '{slot_index: slot_q, references: REF_W'(cnt), status: STAT_OK};
            end else begin
              bm_wr.en   = 1'b1;
              bm_wr.data = bm_rdata & ~sel_mask;
              res_d = '{slot_index: slot_q, references: '0, status: STAT_OK};
            end
          end
          default: begin
            res_d = '{slot_index: slot_q,
                      references: used ? REF_W'(cnt) + REF_W'(1) : '0,
                      status: STAT_OK};
          end
        endcase
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= SLOTS_RESET;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    slot_q <= slot_d;
    aw_q   <= aw_d;
    res_q  <= res_d;
    if (load) begin
      out_res_q <= res_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.slot_index = out_res_q.slot_index;
  assign out_o.references = out_res_q.references;
  assign out_o.status     = out_res_q.status;

  // The read-modify-write step always hands its result on next.
  a_read_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_DONE))
    else $error("read step not followed by result hand-off");

  // Memory writes only come from the read-modify-write step.
  a_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bm_wr.en || rc_req.wr_en) |-> (state_q == S_READ))
    else $error("memory written outside the read-modify-write step");

  // A granted slot always lies below the configured search bound.
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OP_ALLOC && res_q.status == STAT_OK)
      |-> ({1'b0, res_q.slot_index} < bound))
    else $error("allocated slot beyond the search bound");

  // A saturated share reports the maximum reference total.
  a_sat_refs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.status == STAT_SAT) |-> (res_q.references == SAT_REFS))
    else $error("saturated share with wrong reference total");

endmodule

FILE: tb/swap_slot_refcount_allocator_unit_tb.sv
// Self-checking testbench for the swap slot allocator with reference counts.
module swap_slot_refcount_allocator_unit_tb;
  import ssra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 24;
  localparam int CFG_SETTLE      = 6;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int DIRECTED_ROWS   = 25;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [REF_W-1:0]  references;
    logic [STAT_W-1:0] status;
  } slot_result_t;

  // An item may carry a result typed into the script; otherwise the
  // prediction is used.
  typedef struct packed {
    logic         stated;
    slot_result_t value;
  } stated_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [CFG_W-1:0]  cfg_value;
    logic              stated;
    slot_result_t      exp;
  } script_row_t;

  localparam slot_result_t NO_EXP = '0;

  script_row_t directed_script [DIRECTED_ROWS] = '{
    '{ROW_ITEM, OP_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0,    17'd1, STAT_OK}},
    '{ROW_ITEM, OP_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd1,    17'd1, STAT_OK}},
    '{ROW_ITEM, OP_RELEASE, 10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd0, STAT_FREE_REL}},
    '{ROW_ITEM, OP_PEEK,    10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd0, STAT_OK}},
    '{ROW_ITEM, OP_SHARE,   10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd1, STAT_OK}},
    '{ROW_ITEM, OP_SHARE,   10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd2, STAT_OK}},
    '{ROW_ITEM, OP_PEEK,    10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd2, STAT_OK}},
    '{ROW_ITEM, OP_RELEASE, 10'd1023, 11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_RELEASE, 10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd0, STAT_OK}},
    '{ROW_ITEM, OP_RELEASE, 10'd1023, 11'd0,    1'b1, '{10'd1023, 17'd0, STAT_FREE_REL}},
    '{ROW_ITEM, OP_RELEASE, 10'd0,    11'd0,    1'b1, '{10'd0,    17'd0, STAT_OK}},
    '{ROW_ITEM, OP_ALLOC,   10'd1023, 11'd0,    1'b1, '{10'd0,    17'd1, STAT_OK}},
    '{ROW_ITEM, OP_SHARE,   10'd0,    11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_SHARE,   10'd682,  11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_SHARE,   10'd341,  11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_RELEASE, 10'd682,  11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_PEEK,    10'd341,  11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_PEEK,    10'd512,  11'd0,    1'b0, NO_EXP},
    '{ROW_CFG,  OP_ALLOC,   10'd0,    11'd0,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0,    17'd0, STAT_FULL}},
    '{ROW_CFG,  OP_ALLOC,   10'd0,    11'd1,    1'b0, NO_EXP},
    '{ROW_ITEM, OP_ALLOC,   10'd0,    11'd0,    1'b1, '{10'd0,    17'd0, STAT_FULL}},
    '{ROW_CFG,  OP_ALLOC,   10'd0,    11'd2047, 1'b0, NO_EXP},
    '{ROW_ITEM, OP_ALLOC,   10'd0,    11'd0,    1'b0, NO_EXP},
    '{ROW_CFG,  OP_ALLOC,   10'd0,    11'd1024, 1'b0, NO_EXP}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  ssra_in_if  in_ch ();
  ssra_out_if out_ch ();

  swap_slot_refcount_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Mirror of the allocator state.
  bit                    slot_taken [NUM_SLOTS] = '{default: 1'b0};
  logic [COUNT_BITS-1:0] share_count [NUM_SLOTS] = '{default: '0};
  logic [CFG_W-1:0]      slots_limit = SLOTS_RESET;

  slot_result_t   pending_results [$];
  stated_result_t stated_results [$];
  logic [SLOT_W-1:0] recent_slots [8] = '{default: '0};

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  hold_off_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic slot_result_t apply_slot_op(input logic [OP_W-1:0] op,
                                                 input logic [SLOT_W-1:0] s);
    slot_result_t r;
    int bound;
    r.slot_index = s;
    r.references = '0;
    r.status     = STAT_OK;
    bound = (slots_limit > NUM_SLOTS) ? NUM_SLOTS : int'(slots_limit);
    if (op == OP_ALLOC) begin
      r.slot_index = '0;
      r.status     = STAT_FULL;
      for (int i = 0; i < bound; i++) begin
        if (!slot_taken[i]) begin
          slot_taken[i]  = 1'b1;
          share_count[i] = '0;
          r.slot_index   = SLOT_W'(i);
          r.references   = REF_W'(1);
          r.status       = STAT_OK;
          break;
        end
      end
    end else if (int'(s) >= NUM_SLOTS) begin
      if (op != OP_PEEK) r.status = STAT_FREE_REL;
    end else begin
      case (op)
        OP_SHARE: begin
          if (!slot_taken[s]) begin
            slot_taken[s]  = 1'b1;
            share_count[s] = '0;
            r.references   = REF_W'(1);
          end else if (share_count[s] == '1) begin
            // The count holds at its maximum; the slot keeps its references.
            r.references = REF_W'(share_count[s]) + 1'b1;
            r.status     = STAT_SAT;
          end else begin
            share_count[s] = share_count[s] + 1'b1;
            r.references   = REF_W'(share_count[s]) + 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!slot_taken[s]) begin
            r.status = STAT_FREE_REL;
          end else if (share_count[s] != '0) begin
            share_count[s] = share_count[s] - 1'b1;
            r.references   = REF_W'(share_count[s]) + 1'b1;
          end else begin
            slot_taken[s] = 1'b0;
          end
        end
        default: begin
          r.references = slot_taken[s] ? REF_W'(share_count[s]) + 1'b1 : '0;
        end
      endcase
    end
    return r;
  endfunction

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    slot_result_t   want;
    stated_result_t note;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: slot_index %0d references %0d status %0d",
                 out_ch.slot_index, out_ch.references, out_ch.status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_ch.slot_index);
            mismatch_count++;
          end
          if (out_ch.references !== want.references) begin
            $error("references: expected %0d, got %0d", want.references, out_ch.references);
            mismatch_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_slot_op(in_ch.opcode, in_ch.slot);
        note = stated_results.pop_front();
        if (in_ch.opcode == OP_ALLOC && want.status == STAT_OK)
          recent_slots[$urandom_range(0, 7)] = want.slot_index;
        pending_results.push_back(note.stated ? note.value : want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("swap_slot_refcount_allocator_unit_tb failed");
      $finish;
    end
  end

  // Result side: random ready runs, free-flowing stretches and one long hold-off.
  initial begin
    bit level;
    int run_len;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        level = ($urandom_range(0, 3) != 0);
        if (!level) run_len = $urandom_range(1, 6);
        else if ($urandom_range(0, 4) == 0) run_len = $urandom_range(20, 60);
        else run_len = $urandom_range(1, 8);
        out_ch.ready = level;
        repeat (run_len) @(negedge clk_i);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s,
                           input logic stated, input slot_result_t exp);
    stated_results.push_back('{stated, exp});
    in_ch.opcode = op;
    in_ch.slot   = s;
    in_ch.valid  = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic program_slot_limit(input logic [CFG_W-1:0] value);
    wait_all_results();
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we      = 1'b0;
    slots_limit = value;
  endtask

  task automatic pick_random_item(output logic [OP_W-1:0] op, output logic [SLOT_W-1:0] s);
    int bound;
    int hot;
    int r;
    bound = (slots_limit > NUM_SLOTS) ? NUM_SLOTS : int'(slots_limit);
    hot = (bound < 4) ? 4 : ((bound > 48) ? 48 : bound);
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_ALLOC;
    else if (r < 62) op = OP_SHARE;
    else if (r < 92) op = OP_RELEASE;
    else op = OP_PEEK;
    // Mostly slots that are likely in use, so counts build up and drain.
    r = $urandom_range(0, 99);
    if (r < 55) s = SLOT_W'($urandom_range(0, hot - 1));
    else if (r < 85) s = recent_slots[$urandom_range(0, 7)];
    else s = SLOT_W'($urandom());
  endtask

  initial begin
    int phase_limits [NUM_PHASES];
    int burst_left;
    int gap;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] s;

    phase_limits = '{1024, 5, 0, 2047, 1, 40, 1024, 0};
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_ALLOC;
    in_ch.slot   = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = SLOTS_RESET;
    phase_limits[NUM_PHASES-1] = $urandom_range(2, 64);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_script[i]) begin
      if (directed_script[i].kind == ROW_CFG) begin
        program_slot_limit(directed_script[i].cfg_value);
      end else begin
        send_item(directed_script[i].op, directed_script[i].slot,
                  directed_script[i].stated, directed_script[i].exp);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_slot_limit(CFG_W'(phase_limits[p]));
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 40) begin
          // Keep offering items while the result side is held off.
          hold_off_req = 1'b1;
          burst_left   = 40;
        end
        if (p == 4 && n == 60) wait_all_results();
        if (burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                    : $urandom_range(1, 12);
        end
        pick_random_item(op, s);
        send_item(op, s, 1'b0, NO_EXP);
        burst_left--;
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("swap_slot_refcount_allocator_unit_tb passed");
    end else begin
      $display("swap_slot_refcount_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule
